@@ hdl/csvf_pkg.sv @@
// ----------------------------------------------------------------------------
// csvf_pkg
// Shared types and constants of the cell / sphere overlap counter.
// ----------------------------------------------------------------------------
package csvf_pkg;

   localparam int MaxSubdivisions = 16;
   localparam int MaxDimensions   = 3;
   localparam int CoordBits       = 32;

   // Doubled coordinate differences, including the farthest sample point of an
   // arbitrary sub-cell step, need a few guard bits.
   localparam int DiffBits = 38;
   localparam int SqBits   = 2 * DiffBits;
   localparam int SumBits  = SqBits + 2;

   localparam logic [30:0] Sqrt2Q30 = 31'd1518500250;
   localparam logic [30:0] Sqrt3Q30 = 31'd1859775394;

   // Register indexes.
   localparam logic [2:0] RegCentreX   = 3'd0;
   localparam logic [2:0] RegCentreY   = 3'd1;
   localparam logic [2:0] RegCentreZ   = 3'd2;
   localparam logic [2:0] RegRadius    = 3'd3;
   localparam logic [2:0] RegCellSize  = 3'd4;
   localparam logic [2:0] RegSubStep   = 3'd5;
   localparam logic [2:0] RegSubdivs   = 3'd6;
   localparam logic [2:0] RegDims      = 3'd7;

   // Overlap classes.
   localparam logic [1:0] ClassOutside = 2'd0;
   localparam logic [1:0] ClassInside  = 2'd1;
   localparam logic [1:0] ClassSampled = 2'd2;

   typedef struct packed {
      logic signed [31:0] cell_x;
      logic signed [31:0] cell_y;
      logic signed [31:0] cell_z;
   } req_type;

   typedef struct packed {
      logic [12:0] inside_count;
      logic [12:0] sample_total;
      logic [1:0]  overlap_class;
   } rsp_type;

   typedef struct packed {
      logic signed [31:0] centre_x;
      logic signed [31:0] centre_y;
      logic signed [31:0] centre_z;
      logic [30:0]        radius;
      logic [30:0]        cell_size;
      logic [30:0]        sub_step;
      logic [4:0]         subdivisions;
      logic [1:0]         dimensions;
   } cfg_type;

   // Work handed from the classifier to the sampler.
   typedef struct packed {
      logic [1:0]                  nd;
      logic [4:0]                  n;
      logic [12:0]                 total;
      logic [1:0]                  cls;
      logic signed [DiffBits-1:0]  base_x;
      logic signed [DiffBits-1:0]  base_y;
      logic signed [DiffBits-1:0]  base_z;
   } job_type;

endpackage

@@ hdl/csvf_front.sv @@
// ----------------------------------------------------------------------------
// csvf_front
// Classifies one cell as outside, fully inside or to be sampled, over a few
// sequenced steps that share one squaring multiplier.
// ----------------------------------------------------------------------------
module csvf_front (
   input  logic                 clock,
   input  logic                 reset,
   input  csvf_pkg::cfg_type    cfg,
   input  logic                 req_push,
   output logic                 req_full,
   input  csvf_pkg::req_type    req_data,
   output logic                 job_valid,
   input  logic                 job_ready,
   output csvf_pkg::job_type    job_data
);

   localparam logic [2:0] StIdle  = 3'd0;
   localparam logic [2:0] StAxis  = 3'd1;
   localparam logic [2:0] StRsq   = 3'd2;
   localparam logic [2:0] StDiag  = 3'd3;
   localparam logic [2:0] StMarg  = 3'd4;
   localparam logic [2:0] StDec   = 3'd5;
   localparam logic [2:0] StOut   = 3'd6;

   localparam int DB = csvf_pkg::DiffBits;
   localparam int SB = csvf_pkg::SumBits;

   logic [2:0]               state_ff, state_in;
   logic [1:0]               axis_ff, axis_in;
   logic [1:0]               nd_ff, nd_in;
   logic [4:0]               n_ff, n_in;
   logic [12:0]              total_ff, total_in;
   logic signed [DB-1:0]     p2_ff [3];
   logic signed [DB-1:0]     p2_in [3];
   logic [SB-1:0]            dsq_ff, dsq_in;
   logic [SB-1:0]            rsq_ff, rsq_in;
   logic [32:0]              diag_ff, diag_in;
   logic [SB-1:0]            msq_ff, msq_in;
   logic                     marg_ok_ff, marg_ok_in;
   csvf_pkg::job_type        job_ff, job_in;

   logic signed [DB-1:0]     cs2, ss2, cen, lo_d, hi_d, near_d;
   logic [DB-1:0]            mul_a;
   logic [2*DB-1:0]          sq;
   logic [61:0]              dprod;
   logic [32:0]              r2;

   assign req_full  = (state_ff != StIdle);
   assign job_valid = (state_ff == StOut);
   assign job_data  = job_ff;

   assign cs2 = DB'(cfg.cell_size);
   assign ss2 = DB'(cfg.sub_step);
   assign r2  = {1'b0, cfg.radius, 1'b0};

   always_comb begin
      unique case (axis_ff)
         2'd0:    cen = DB'(cfg.centre_x) <<< 1;
         2'd1:    cen = DB'(cfg.centre_y) <<< 1;
         default: cen = DB'(cfg.centre_z) <<< 1;
      endcase
   end

   // Distance from the centre to the nearest point of the cell on one axis.
   always_comb begin
      lo_d = p2_ff[axis_ff] - cs2 - cen;
      hi_d = p2_ff[axis_ff] + cs2 - cen;
      if (lo_d > 0) begin
         near_d = lo_d;
      end else if (hi_d < 0) begin
         near_d = hi_d;
      end else begin
         near_d = '0;
      end
   end

   // The one shared squarer.
   always_comb begin
      case (state_ff)
         StRsq:   mul_a = DB'(r2);
         StMarg:  mul_a = DB'(r2 - diag_ff);
         default: mul_a = near_d[DB-1] ? DB'(-near_d) : DB'(near_d);
      endcase
      sq = mul_a * mul_a;
   end

   always_comb begin
      if (nd_ff == 2'd2) begin
         dprod = 62'(cfg.cell_size) * 62'(csvf_pkg::Sqrt2Q30);
      end else begin
         dprod = 62'(cfg.cell_size) * 62'(csvf_pkg::Sqrt3Q30);
      end
   end

   always_comb begin
      state_in   = state_ff;
      axis_in    = axis_ff;
      nd_in      = nd_ff;
      n_in       = n_ff;
      total_in   = total_ff;
      p2_in      = p2_ff;
      dsq_in     = dsq_ff;
      rsq_in     = rsq_ff;
      diag_in    = diag_ff;
      msq_in     = msq_ff;
      marg_ok_in = marg_ok_ff;
      job_in     = job_ff;
      unique case (state_ff)
         StIdle: begin
            if (req_push) begin
               nd_in = (cfg.dimensions == 2'd0) ? 2'd1 : cfg.dimensions;
               if (cfg.subdivisions == 5'd0) begin
                  n_in = 5'd1;
               end else if (cfg.subdivisions > 5'(csvf_pkg::MaxSubdivisions)) begin
                  n_in = 5'(csvf_pkg::MaxSubdivisions);
               end else begin
                  n_in = cfg.subdivisions;
               end
               p2_in[0] = DB'(req_data.cell_x) <<< 1;
               p2_in[1] = DB'(req_data.cell_y) <<< 1;
               p2_in[2] = DB'(req_data.cell_z) <<< 1;
               axis_in  = 2'd0;
               dsq_in   = '0;
               total_in = 13'd1;
               state_in = StAxis;
            end
         end
         StAxis: begin
            dsq_in   = dsq_ff + SB'(sq);
            total_in = 13'(total_ff * 13'(n_ff));
            if (axis_ff == nd_ff - 2'd1) begin
               state_in = StRsq;
            end else begin
               axis_in = axis_ff + 2'd1;
            end
         end
         StRsq: begin
            rsq_in = SB'(sq);
            unique case (nd_ff)
               2'd1:    diag_in = {1'b0, cfg.cell_size, 1'b0};
               default: diag_in = 33'((dprod + 62'h1FFFFFFF) >> 29);
            endcase
            state_in = StDiag;
         end
         StDiag: begin
            marg_ok_in = diag_ff < r2;
            state_in   = StMarg;
         end
         StMarg: begin
            msq_in   = SB'(sq);
            state_in = StDec;
         end
         StDec: begin
            job_in.nd    = nd_ff;
            job_in.n     = n_ff;
            job_in.total = total_ff;
            job_in.base_x = p2_ff[0] - cs2 + ss2 - (DB'(cfg.centre_x) <<< 1);
            job_in.base_y = p2_ff[1] - cs2 + ss2 - (DB'(cfg.centre_y) <<< 1);
            job_in.base_z = p2_ff[2] - cs2 + ss2 - (DB'(cfg.centre_z) <<< 1);
            if (dsq_ff > rsq_ff) begin
               job_in.cls = csvf_pkg::ClassOutside;
            end else if (marg_ok_ff && (msq_ff > dsq_ff)) begin
               job_in.cls = csvf_pkg::ClassInside;
            end else begin
               job_in.cls = csvf_pkg::ClassSampled;
            end
            state_in = StOut;
         end
         StOut: begin
            if (job_ready) begin
               state_in = StIdle;
            end
         end
         default: state_in = StIdle;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= StIdle;
      end else begin
         state_ff <= state_in;
      end
      axis_ff    <= axis_in;
      nd_ff      <= nd_in;
      n_ff       <= n_in;
      total_ff   <= total_in;
      p2_ff      <= p2_in;
      dsq_ff     <= dsq_in;
      rsq_ff     <= rsq_in;
      diag_ff    <= diag_in;
      msq_ff     <= msq_in;
      marg_ok_ff <= marg_ok_in;
      job_ff     <= job_in;
   end

endmodule

@@ hdl/csvf_queue.sv @@
// ----------------------------------------------------------------------------
// csvf_queue
// Two-entry queue that carries classified jobs from the front to the back.
// ----------------------------------------------------------------------------
module csvf_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  csvf_pkg::job_type    in_data,
   output logic                 out_valid,
   input  logic                 out_ready,
   output csvf_pkg::job_type    out_data
);

   csvf_pkg::job_type mem_ff [2];
   logic              wp_ff, rp_ff;
   logic [1:0]        cnt_ff;
   logic              wr, rd;

   assign in_ready  = (cnt_ff != 2'd2);
   assign out_valid = (cnt_ff != 2'd0);
   assign out_data  = mem_ff[rp_ff];
   assign wr = in_valid && in_ready;
   assign rd = out_valid && out_ready;

   // Pointer and occupancy update on every transfer.
   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (wr) wp_ff <= ~wp_ff;
         if (rd) rp_ff <= ~rp_ff;
         cnt_ff <= cnt_ff + {1'b0, wr} - {1'b0, rd};
      end
      if (wr) mem_ff[wp_ff] <= in_data;
   end

endmodule

@@ hdl/csvf_back.sv @@
// ----------------------------------------------------------------------------
// csvf_back
// Walks the sample grid of a boundary cell one point per cycle (three
// pipelined squarers and an adder) and holds the result for the consumer.
// ----------------------------------------------------------------------------
module csvf_back (
   input  logic                 clock,
   input  logic                 reset,
   input  csvf_pkg::cfg_type    cfg,
   input  logic                 job_valid,
   output logic                 job_ready,
   input  csvf_pkg::job_type    job_data,
   output logic                 rsp_empty,
   input  logic                 rsp_pop,
   output csvf_pkg::rsp_type    rsp_data
);

   localparam logic [1:0] StIdle = 2'd0;
   localparam logic [1:0] StRun  = 2'd1;
   localparam logic [1:0] StHold = 2'd2;

   localparam int DB = csvf_pkg::DiffBits;
   localparam int QB = csvf_pkg::SqBits;
   localparam int SB = csvf_pkg::SumBits;

   logic [1:0]           state_ff, state_in;
   csvf_pkg::job_type    job_ff, job_in;
   logic [SB-1:0]        rsq_ff;
   logic [3:0]           dx_ff, dy_ff, dz_ff, dx_in, dy_in, dz_in;
   logic [12:0]          issued_ff, issued_in;
   logic [12:0]          count_ff, count_in;
   logic [1:0]           vld_ff;
   logic [1:0]           vld_in;
   logic signed [DB-1:0] cx_ff, cy_ff, cz_ff, cx_in, cy_in, cz_in;
   logic [DB-1:0]        mx, my, mz;
   logic [QB-1:0]        sx_ff, sy_ff, sz_ff;
   logic                 hit;
   logic signed [DB-1:0] step2;
   logic [4:0]           nm1;
   csvf_pkg::rsp_type    out_ff, out_in;
   logic [32:0]          r2;

   assign step2     = DB'(cfg.sub_step) <<< 1;
   assign r2        = {1'b0, cfg.radius, 1'b0};
   assign job_ready = (state_ff == StIdle);
   assign rsp_empty = (state_ff != StHold);
   assign rsp_data  = out_ff;
   assign nm1       = job_ff.n - 5'd1;

   // Magnitudes of the sample point offsets.
   assign mx = cx_ff[DB-1] ? -cx_ff : cx_ff;
   assign my = cy_ff[DB-1] ? -cy_ff : cy_ff;
   assign mz = cz_ff[DB-1] ? -cz_ff : cz_ff;

   // Squares registered, then summed and compared with the radius squared.
   always_ff @(posedge clock) begin
      sx_ff  <= mx * mx;
      sy_ff  <= my * my;
      sz_ff  <= mz * mz;
      rsq_ff <= r2 * r2;
   end

   always_comb begin
      hit = (SB'(sx_ff) + (job_ff.nd > 2'd1 ? SB'(sy_ff) : SB'(0))
             + (job_ff.nd > 2'd2 ? SB'(sz_ff) : SB'(0))) <= rsq_ff;
   end

   always_comb begin
      state_in  = state_ff;
      job_in    = job_ff;
      dx_in     = dx_ff;
      dy_in     = dy_ff;
      dz_in     = dz_ff;
      cx_in     = cx_ff;
      cy_in     = cy_ff;
      cz_in     = cz_ff;
      issued_in = issued_ff;
      count_in  = count_ff;
      vld_in    = {vld_ff[0], 1'b0};
      out_in    = out_ff;
      unique case (state_ff)
         StIdle: begin
            if (job_valid) begin
               job_in = job_data;
               out_in.sample_total  = job_data.total;
               out_in.overlap_class = job_data.cls;
               if (job_data.cls == csvf_pkg::ClassOutside) begin
                  out_in.inside_count = '0;
                  state_in = StHold;
               end else if (job_data.cls == csvf_pkg::ClassInside) begin
                  out_in.inside_count = job_data.total;
                  state_in = StHold;
               end else begin
                  dx_in = '0; dy_in = '0; dz_in = '0;
                  cx_in = job_data.base_x;
                  cy_in = job_data.base_y;
                  cz_in = job_data.base_z;
                  issued_in = '0;
                  count_in  = '0;
                  state_in  = StRun;
               end
            end
         end
         StRun: begin
            // Issue one sample point a cycle; x is the fastest digit.
            if (issued_ff != job_ff.total) begin
               vld_in[0] = 1'b1;
               issued_in = issued_ff + 13'd1;
               if (dx_ff != nm1[3:0]) begin
                  dx_in = dx_ff + 4'd1;
                  cx_in = cx_ff + step2;
               end else begin
                  dx_in = '0;
                  cx_in = job_ff.base_x;
                  if (dy_ff != nm1[3:0]) begin
                     dy_in = dy_ff + 4'd1;
                     cy_in = cy_ff + step2;
                  end else begin
                     dy_in = '0;
                     cy_in = job_ff.base_y;
                     dz_in = dz_ff + 4'd1;
                     cz_in = cz_ff + step2;
                  end
               end
            end
            // The registered squares belong to the point issued in the cycle before.
            if (vld_ff[0] && hit) begin
               count_in = count_ff + 13'd1;
            end
            if (issued_ff == job_ff.total && vld_ff == 2'b00) begin
               out_in.inside_count = count_ff;
               state_in = StHold;
            end
         end
         StHold: begin
            if (rsp_pop) begin
               state_in = StIdle;
            end
         end
         default: state_in = StIdle;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= StIdle;
         vld_ff   <= '0;
      end else begin
         state_ff <= state_in;
         vld_ff   <= vld_in;
      end
      job_ff    <= job_in;
      dx_ff     <= dx_in;
      dy_ff     <= dy_in;
      dz_ff     <= dz_in;
      cx_ff     <= cx_in;
      cy_ff     <= cy_in;
      cz_ff     <= cz_in;
      issued_ff <= issued_in;
      count_ff  <= count_in;
      out_ff    <= out_in;
   end

endmodule

@@ hdl/cell_sphere_volume_fraction.sv @@
// ----------------------------------------------------------------------------
// cell_sphere_volume_fraction
// Counts the sub-cell sample points of one grid cell that lie in a sphere.
// ----------------------------------------------------------------------------
// A cell is taken from the request queue interface and classified by a
// sequencer with one shared squarer; it hands its job on after its axis,
// radius, diagonal, margin and decision steps and takes the next cell in the
// cycle after the handoff, so it takes no new cell while it works on one.
// Cells wholly outside or wholly inside the sphere skip the sampling. A
// boundary cell is sampled at one point per cycle, on a grid of up to 16
// points per axis in 3D; the sampler takes no new job until its result is
// popped, and so sets the rate. A two-entry job queue lets the classifier
// take the next cell while the sampler works. Registers must be written only
// while idle; the block itself does not enforce this.
module cell_sphere_volume_fraction (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_push,
   output logic                 req_full,
   input  csvf_pkg::req_type    req_data,
   output logic                 rsp_empty,
   input  logic                 rsp_pop,
   output csvf_pkg::rsp_type    rsp_data,
   input  logic                 csr_write,
   input  logic [2:0]           csr_index,
   input  logic [31:0]          csr_data
);

   csvf_pkg::cfg_type cfg_ff;
   logic              fj_valid, fj_ready, bj_valid, bj_ready;
   csvf_pkg::job_type fj_data, bj_data;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.centre_x     <= '0;
         cfg_ff.centre_y     <= '0;
         cfg_ff.centre_z     <= '0;
         cfg_ff.radius       <= 31'd65536;
         cfg_ff.cell_size    <= 31'd65536;
         cfg_ff.sub_step     <= 31'd16384;
         cfg_ff.subdivisions <= 5'd4;
         cfg_ff.dimensions   <= 2'd3;
      end else if (csr_write) begin
         unique case (csr_index)
            csvf_pkg::RegCentreX:  cfg_ff.centre_x     <= csr_data;
            csvf_pkg::RegCentreY:  cfg_ff.centre_y     <= csr_data;
            csvf_pkg::RegCentreZ:  cfg_ff.centre_z     <= csr_data;
            csvf_pkg::RegRadius:   cfg_ff.radius       <= csr_data[30:0];
            csvf_pkg::RegCellSize: cfg_ff.cell_size    <= csr_data[30:0];
            csvf_pkg::RegSubStep:  cfg_ff.sub_step     <= csr_data[30:0];
            csvf_pkg::RegSubdivs:  cfg_ff.subdivisions <= csr_data[4:0];
            default:               cfg_ff.dimensions   <= csr_data[1:0];
         endcase
      end
   end

   csvf_front u_front (
      .clock(clock), .reset(reset), .cfg(cfg_ff),
      .req_push(req_push), .req_full(req_full), .req_data(req_data),
      .job_valid(fj_valid), .job_ready(fj_ready), .job_data(fj_data)
   );

   csvf_queue u_queue (
      .clock(clock), .reset(reset),
      .in_valid(fj_valid), .in_ready(fj_ready), .in_data(fj_data),
      .out_valid(bj_valid), .out_ready(bj_ready), .out_data(bj_data)
   );

   csvf_back u_back (
      .clock(clock), .reset(reset), .cfg(cfg_ff),
      .job_valid(bj_valid), .job_ready(bj_ready), .job_data(bj_data),
      .rsp_empty(rsp_empty), .rsp_pop(rsp_pop), .rsp_data(rsp_data)
   );

endmodule

@@ tb/sv/tb_cell_sphere_volume_fraction.sv @@
// ----------------------------------------------------------------------------
// tb_cell_sphere_volume_fraction
// Self-checking bench of the cell / sphere overlap counter. Cells are pushed
// through the request queue with random gaps, results are popped with random
// stalls, and each result is compared against a behavioural model held in a
// small scoreboard class. Several register settings are exercised, the
// extremes among them.
// ----------------------------------------------------------------------------
module tb_cell_sphere_volume_fraction;
   timeunit 1ns;
   timeprecision 1ps;

   // Four 64-bit words make a 256-bit sum, ample for the squared distances.
   typedef logic [255:0] wide_sum_type;

   // Scoreboard: holds the register copy and the queue of predicted overlaps.
   class scoreboard_type;
      csvf_pkg::cfg_type cfg;
      csvf_pkg::rsp_type pending[$];
      int      errors;
      int      checked;
      int      class_seen[3];

      function void reset_cfg();
         cfg.centre_x = 0; cfg.centre_y = 0; cfg.centre_z = 0;
         cfg.radius = 31'd65536; cfg.cell_size = 31'd65536;
         cfg.sub_step = 31'd16384; cfg.subdivisions = 5'd4; cfg.dimensions = 2'd3;
      endfunction

      function void write_reg(logic [2:0] idx, logic [31:0] val);
         case (idx)
            csvf_pkg::RegCentreX: cfg.centre_x = val;
            csvf_pkg::RegCentreY: cfg.centre_y = val;
            csvf_pkg::RegCentreZ: cfg.centre_z = val;
            csvf_pkg::RegRadius: cfg.radius = val[30:0];
            csvf_pkg::RegCellSize: cfg.cell_size = val[30:0];
            csvf_pkg::RegSubStep: cfg.sub_step = val[30:0];
            csvf_pkg::RegSubdivs: cfg.subdivisions = val[4:0];
            default: cfg.dimensions = val[1:0];
         endcase
      endfunction

      function wide_sum_type square_of(longint signed d);
         logic [63:0] mag;
         mag = (d < 0) ? -d : d;
         return wide_sum_type'(mag) * wide_sum_type'(mag);
      endfunction

      // Works out the overlap of one accepted cell and queues it.
      function void note_cell(csvf_pkg::req_type item);
         longint signed p2[3], c2[3], base[3];
         longint signed cs, ss, lo, hi, d, digit;
         int nd, n, total, count, rest;
         logic [63:0] r2, diag2;
         wide_sum_type dsq, rsq, s;
         logic [1:0] cls;
         csvf_pkg::rsp_type res;
         cs = cfg.cell_size; ss = cfg.sub_step;
         nd = cfg.dimensions; n = cfg.subdivisions;
         if (nd < 1) nd = 1;
         if (n < 1) n = 1;
         if (n > csvf_pkg::MaxSubdivisions) n = csvf_pkg::MaxSubdivisions;
         total = 1;
         for (int v = 0; v < nd; v++) total *= n;
         c2[0] = 2 * longint'(cfg.centre_x);
         c2[1] = 2 * longint'(cfg.centre_y);
         c2[2] = 2 * longint'(cfg.centre_z);
         p2[0] = 2 * longint'(item.cell_x);
         p2[1] = 2 * longint'(item.cell_y);
         p2[2] = 2 * longint'(item.cell_z);
         dsq = 0;
         for (int v = 0; v < nd; v++) begin
            lo = p2[v] - cs - c2[v];
            hi = p2[v] + cs - c2[v];
            d = (lo > 0) ? lo : ((hi < 0) ? hi : 0);
            dsq += square_of(d);
         end
         r2 = 2 * 64'(cfg.radius);
         rsq = wide_sum_type'(r2) * wide_sum_type'(r2);
         if (nd == 1) diag2 = 2 * 64'(cfg.cell_size);
         else if (nd == 2)
            diag2 = (64'(csvf_pkg::Sqrt2Q30) * cfg.cell_size + 64'h1FFFFFFF) >> 29;
         else
            diag2 = (64'(csvf_pkg::Sqrt3Q30) * cfg.cell_size + 64'h1FFFFFFF) >> 29;
         count = 0;
         if (dsq > rsq) begin
            cls = csvf_pkg::ClassOutside;
         end else if (diag2 < r2 &&
                      wide_sum_type'(r2 - diag2) * wide_sum_type'(r2 - diag2) > dsq) begin
            cls = csvf_pkg::ClassInside;
            count = total;
         end else begin
            cls = csvf_pkg::ClassSampled;
            for (int v = 0; v < nd; v++) base[v] = p2[v] - cs + ss - c2[v];
            for (int k = 0; k < total; k++) begin
               rest = k;
               s = 0;
               for (int v = 0; v < nd; v++) begin
                  digit = rest % n;
                  rest = rest / n;
                  s += square_of(base[v] + 2 * digit * ss);
               end
               if (s <= rsq) count++;
            end
         end
         res.inside_count = count[12:0];
         res.sample_total = total[12:0];
         res.overlap_class = cls;
         pending.push_back(res);
      endfunction

      // Compares one popped result with the oldest prediction.
      function void check_result(csvf_pkg::rsp_type got);
         csvf_pkg::rsp_type want;
         if (pending.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected result %p", got);
            return;
         end
         want = pending.pop_front();
         checked++;
         if (want.overlap_class <= csvf_pkg::ClassSampled) class_seen[want.overlap_class]++;
         if (got.inside_count !== want.inside_count ||
             got.sample_total !== want.sample_total ||
             got.overlap_class !== want.overlap_class) begin
            errors++;
            if (errors <= 10)
               $display("mismatch: count %0d/%0d total %0d/%0d class %0d/%0d (exp/act)",
                        want.inside_count, got.inside_count, want.sample_total,
                        got.sample_total, want.overlap_class, got.overlap_class);
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_push = 1'b0;
   logic req_full;
   csvf_pkg::req_type req_data = '0;
   logic rsp_empty;
   logic rsp_pop = 1'b0;
   csvf_pkg::rsp_type rsp_data;
   logic csr_write = 1'b0;
   logic [2:0] csr_index = csvf_pkg::RegCentreX;
   logic [31:0] csr_data = '0;

   scoreboard_type board = new();
   bit sending_done = 0;
   int cells_sent = 0;

   cell_sphere_volume_fraction dut (.*);

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Pushes one cell and waits for its transfer; push stays high only when
   // the next cell follows with no gap.
   task automatic push_cell(logic [31:0] x, logic [31:0] y, logic [31:0] z);
      int gap;
      gap = $urandom_range(0, 11);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap != 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_push <= 1'b1;
      req_data <= '{cell_x: x, cell_y: y, cell_z: z};
      do @(posedge clock); while (req_full);
      board.note_cell('{cell_x: x, cell_y: y, cell_z: z});
      cells_sent++;
   endtask

   // Waits until every predicted result has been popped, then a little more.
   task automatic drain();
      req_push <= 1'b0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_reg(logic [2:0] idx, logic [31:0] val);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      board.write_reg(idx, val);
      csr_write <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_sphere(logic [31:0] cx, logic [31:0] cy, logic [31:0] cz,
                             logic [31:0] rad, logic [31:0] cs, logic [4:0] sub,
                             logic [1:0] dims);
      drain();
      write_reg(csvf_pkg::RegCentreX, cx);
      write_reg(csvf_pkg::RegCentreY, cy);
      write_reg(csvf_pkg::RegCentreZ, cz);
      write_reg(csvf_pkg::RegRadius, rad);
      write_reg(csvf_pkg::RegCellSize, cs);
      write_reg(csvf_pkg::RegSubStep, (sub == 0) ? cs : cs / sub);
      write_reg(csvf_pkg::RegSubdivs, sub);
      write_reg(csvf_pkg::RegDims, dims);
   endtask

   // A random cell near the sphere so that all three classes turn up.
   task automatic push_near(int spread);
      logic [31:0] c[3];
      for (int v = 0; v < 3; v++)
         c[v] = (v == 0 ? board.cfg.centre_x : v == 1 ? board.cfg.centre_y
                 : board.cfg.centre_z) + ($urandom_range(0, 2 * spread) - spread);
      push_cell(c[0], c[1], c[2]);
   endtask

   // Result side: random stalls with some stretches of none.
   initial begin
      int stall;
      @(negedge reset);
      forever begin
         stall = $urandom_range(0, 11);
         if ($urandom_range(0, 3) == 0) stall = 0;
         if (stall != 0) begin
            rsp_pop <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_pop <= 1'b1;
         do @(posedge clock); while (rsp_empty);
         board.check_result(rsp_data);
      end
   end

   // Stimulus.
   initial begin
      board.reset_cfg();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: reset settings, extremes of the coordinates.
      push_cell(0, 0, 0);
      push_cell(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      push_cell(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      push_cell(32'h0001_0000, 0, 0);
      push_cell(32'h0000_8000, 32'h0000_8000, 32'h0000_8000);
      push_cell(32'hFFFF_0000, 32'h0000_C000, 0);
      // Wait for every result before going on.
      drain();
      push_cell(32'h0001_8000, 0, 0);

      // Largest grid in 3D on a boundary cell, once.
      set_sphere(0, 0, 0, 32'h0001_0000, 32'h0001_0000, 5'd16, 2'd3);
      push_cell(32'h0001_0000, 0, 0);
      // Zero subdivisions and dimensions, then oversize subdivisions.
      set_sphere(0, 0, 0, 32'h0002_0000, 32'h0001_0000, 5'd0, 2'd0);
      push_cell(32'h0002_0000, 0, 0);
      push_cell(32'h8000_0000, 0, 0);
      set_sphere(0, 0, 0, 32'h0002_0000, 32'h0000_4000, 5'd31, 2'd2);
      push_cell(32'h0001_E000, 32'h0000_8000, 0);
      // Radius extremes and the largest cell size, centre at the corners.
      set_sphere(32'h7FFF_FFFF, 32'h8000_0000, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                 5'd3, 2'd3);
      push_cell(32'h7FFF_FFFF, 32'h8000_0000, 0);
      push_cell(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
      set_sphere(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 0, 1, 5'd2, 2'd1);
      push_cell(32'h8000_0000, 0, 0);
      push_cell(32'h8000_0001, 0, 0);
      // Inconsistent sub-cell step, written after the helper.
      drain();
      write_reg(csvf_pkg::RegSubStep, 32'h0001_0000);
      push_cell(32'h8000_0000, 0, 0);
      drain();
      write_reg(csvf_pkg::RegSubStep, 0);
      write_reg(csvf_pkg::RegCellSize, 0);
      push_cell(32'h8000_0000, 0, 0);

      // Random phases, small grids mostly, several settings.
      for (int phase = 0; phase < 6; phase++) begin
         set_sphere($urandom_range(0, 32'h0008_0000) - 32'h0004_0000,
                    $urandom, $urandom_range(0, 1) ? 32'h0 : $urandom,
                    $urandom_range(32'h0000_4000, 32'h0004_0000),
                    $urandom_range(32'h0000_2000, 32'h0002_0000),
                    5'($urandom_range(1, 6)), 2'($urandom_range(1, 3)));
         // Coordinates away from the sphere still need the upper bits.
         for (int i = 0; i < 20; i++) begin
            if ($urandom_range(0, 7) == 0) push_cell($urandom, $urandom, $urandom);
            else push_near(32'h0006_0000);
         end
      end
      req_push <= 1'b0;
      sending_done = 1;
   end

   // End of run.
   initial begin
      wait (sending_done);
      while (board.pending.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      $display("%0d cells sent, %0d results checked (outside %0d, inside %0d, sampled %0d)",
               cells_sent, board.checked, board.class_seen[0], board.class_seen[1],
               board.class_seen[2]);
      if (board.errors == 0 && board.pending.size() == 0)
         $display("tb_cell_sphere_volume_fraction OK");
      else
         $display("tb_cell_sphere_volume_fraction NOT OK");
      $finish;
   end

   // Watchdog.
   initial begin
      #20ms;
      $display("tb_cell_sphere_volume_fraction NOT OK");
      $finish;
   end

endmodule
